/* src/ffha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Block table geometry, header size, entry/control/report structs, codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int OFS_W      = 16;
  localparam int SIZE_W     = 17;
  localparam int REQ_W      = 18;

  // header bytes, already a multiple of 8
  localparam logic [SIZE_W-1:0] HDR_S    = 17'd32;
  localparam logic [REQ_W-1:0]  HDR_R    = 18'd32;
  localparam logic [SIZE_W-1:0] POOL_MAX = 17'd65536;
  localparam logic [SIZE_W-1:0] POOL_MIN = 17'd64;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BADFREE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [OFS_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              run;
    logic              launch;
    logic              init;
    logic              kind;
    logic              coal;
    logic              can_split;
    logic              ins;
    logic              rem;
    logic [REQ_W-1:0]  req;
    logic [OFS_W-1:0]  addr;
    logic [SIZE_W-1:0] init_size;
  } ctl_t;

  // report of the cell holding the token, zero elsewhere
  typedef struct packed {
    logic             hit;
    logic             split;
    logic             merge;
    logic             at_end;
    logic [OFS_W-1:0] offset;
  } rep_t;

endpackage

/* src/ffha_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_cell: one block table entry
// Holds one entry, checks it when the walk token sits here, and shifts
// entries right (split) or left (merge) along the chain.
// ----------------------------------------------------------------------------
module ffha_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            head,
  input  ffha_pkg::ctl_t  ctl,
  input  ffha_pkg::entry_t left_fwd,
  input  logic            left_tok,
  input  ffha_pkg::entry_t right_ent,
  input  logic            right_merge,
  output ffha_pkg::entry_t ent_q,
  output ffha_pkg::entry_t fwd,
  output logic            tok_fwd,
  output logic            merge_req,
  output ffha_pkg::rep_t  rep
);

  ffha_pkg::entry_t ent;
  logic token;
  logic passed;

  logic alloc_hit;
  logic split;
  logic free_hit;
  logic merge;
  logic stay;
  logic [ffha_pkg::SIZE_W-1:0] data_ofs;
  logic [ffha_pkg::SIZE_W-1:0] rem_start;
  ffha_pkg::entry_t rem_ent;

  always_comb begin
    data_ofs  = {1'b0, ent.start} + ffha_pkg::HDR_S;
    rem_start = data_ofs + ctl.req[ffha_pkg::SIZE_W-1:0];
    alloc_hit = ctl.run && token && (ctl.kind == ffha_pkg::KIND_ALLOC) && ent.valid
                && !ent.used && ({1'b0, ent.size} >= ctl.req);
    split     = alloc_hit && ctl.can_split
                && ({1'b0, ent.size} > (ctl.req + ffha_pkg::HDR_R));
    free_hit  = ctl.run && token && (ctl.kind == ffha_pkg::KIND_FREE) && ent.valid
                && ent.used && (data_ofs == {1'b0, ctl.addr});
    merge     = ctl.run && ctl.coal && token && left_fwd.valid && !left_fwd.used
                && ent.valid && !ent.used;
    stay      = free_hit || merge;
    tok_fwd   = ctl.run && token && !stay;
    merge_req = merge;

    rem_ent.valid = 1'b1;
    rem_ent.used  = 1'b0;
    rem_ent.start = rem_start[ffha_pkg::OFS_W-1:0];
    rem_ent.size  = ent.size - ffha_pkg::HDR_S - ctl.req[ffha_pkg::SIZE_W-1:0];
    fwd           = split ? rem_ent : ent;

    rep.hit    = alloc_hit || free_hit;
    rep.split  = split;
    rep.merge  = merge;
    rep.at_end = ctl.run && token && !ent.valid;
    rep.offset = alloc_hit ? data_ofs[ffha_pkg::OFS_W-1:0] : '0;
    ent_q      = ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= head;
      ent.used  <= 1'b0;
      ent.start <= '0;
      ent.size  <= ffha_pkg::POOL_MAX - ffha_pkg::HDR_S;
      token     <= 1'b0;
      passed    <= 1'b0;
    end else if (ctl.init) begin
      ent.valid <= head;
      ent.used  <= 1'b0;
      ent.start <= '0;
      ent.size  <= head ? ctl.init_size : '0;
      token     <= 1'b0;
      passed    <= 1'b0;
    end else begin
      token <= ctl.run ? ((token && stay) || left_tok) : left_tok;
      if (ctl.launch) begin
        passed <= 1'b0;
      end else if (ctl.run && token && !stay) begin
        passed <= 1'b1;
      end
      if (ctl.run) begin
        if (alloc_hit) begin
          ent.used <= 1'b1;
          if (split) begin
            ent.size <= ctl.req[ffha_pkg::SIZE_W-1:0];
          end
        end else if (free_hit) begin
          ent.used <= 1'b0;
        end else if (ctl.ins && !passed && !token) begin
          // open a slot: take the entry from the left
          ent <= left_fwd;
        end else if (ctl.rem && !passed) begin
          // close the merged slot: pull from the right
          ent <= right_ent;
        end else if (right_merge) begin
          ent.size <= ent.size + right_ent.size + ffha_pkg::HDR_S;
        end
      end
    end
  end

endmodule

/* src/ffha_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl: request sequencer of the first-fit heap allocator
// Takes a request, launches the token down the cell chain, collects the
// cell report, keeps the entry count and drives the result register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         kind,
  input  logic [ffha_pkg::SIZE_W-1:0]  request_bytes,
  input  logic [ffha_pkg::OFS_W-1:0]   block_address,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [1:0]                   status,
  output logic [ffha_pkg::OFS_W-1:0]   data_offset,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffha_pkg::SIZE_W-1:0]  cfg_data,
  input  ffha_pkg::rep_t               rep,
  input  logic                         tok_out,
  output ffha_pkg::ctl_t               ctl
);

  ffha_pkg::state_t state;
  ffha_pkg::state_t state_next;

  logic                        op_kind;
  logic [ffha_pkg::REQ_W-1:0]  op_req;
  logic [ffha_pkg::OFS_W-1:0]  op_addr;
  logic                        coal;
  logic [ffha_pkg::CNT_W-1:0]  count;
  logic [1:0]                  res_status;
  logic [ffha_pkg::OFS_W-1:0]  res_offset;

  logic                        accept;
  logic                        walk_end;
  logic                        walk_done;
  logic                        load_out;
  logic [ffha_pkg::SIZE_W-1:0] pool;
  logic [ffha_pkg::REQ_W-1:0]  req_round;

  always_comb begin
    req_round = ({1'b0, request_bytes} + 18'd7) & ~18'd7;
    if (cfg_data > ffha_pkg::POOL_MAX) begin
      pool = ffha_pkg::POOL_MAX;
    end else if (cfg_data < ffha_pkg::POOL_MIN) begin
      pool = ffha_pkg::POOL_MIN;
    end else begin
      pool = cfg_data;
    end
    walk_end = rep.at_end || tok_out;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready) state_next = ffha_pkg::ST_WALK;
      end
      ffha_pkg::ST_WALK: begin
        if (op_kind == ffha_pkg::KIND_ALLOC) begin
          if (rep.hit || walk_end) state_next = ffha_pkg::ST_HOLD;
        end else if (walk_end) begin
          state_next = ffha_pkg::ST_HOLD;
        end
      end
      ffha_pkg::ST_HOLD: begin
        if (!m_tvalid || m_tready) state_next = ffha_pkg::ST_IDLE;
      end
      default: state_next = ffha_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = 1'b0;
    cfg_ready = 1'b0;
    walk_done = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ffha_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        s_tready  = !cfg_valid;
      end
      ffha_pkg::ST_WALK: begin
        walk_done = (op_kind == ffha_pkg::KIND_ALLOC) ? (rep.hit || walk_end) : walk_end;
      end
      ffha_pkg::ST_HOLD: begin
        load_out = !m_tvalid || m_tready;
      end
      default: ;
    endcase
    accept = s_tvalid && s_tready;

    ctl.run       = (state == ffha_pkg::ST_WALK);
    ctl.launch    = accept;
    ctl.init      = cfg_valid && cfg_ready;
    ctl.kind      = op_kind;
    ctl.coal      = coal;
    ctl.can_split = (count != ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS));
    ctl.ins       = rep.split;
    ctl.rem       = rep.merge;
    ctl.req       = op_req;
    ctl.addr      = op_addr;
    ctl.init_size = pool - ffha_pkg::HDR_S;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffha_pkg::ST_IDLE;
      count    <= ffha_pkg::CNT_W'(1);
      coal     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.init) begin
        count <= ffha_pkg::CNT_W'(1);
      end else if (ctl.run && rep.split) begin
        count <= count + 1'b1;
      end else if (ctl.run && rep.merge) begin
        count <= count - 1'b1;
      end
      if (accept) begin
        coal <= 1'b0;
      end else if (ctl.run && op_kind == ffha_pkg::KIND_FREE && rep.hit) begin
        coal <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= kind;
      op_req  <= req_round;
      op_addr <= block_address;
    end
    if (walk_done) begin
      if (op_kind == ffha_pkg::KIND_ALLOC) begin
        res_status <= rep.hit ? ffha_pkg::STAT_OK : ffha_pkg::STAT_NOSPACE;
        res_offset <= rep.hit ? rep.offset : '0;
      end else begin
        res_status <= coal ? ffha_pkg::STAT_OK : ffha_pkg::STAT_BADFREE;
        res_offset <= '0;
      end
    end
    if (load_out) begin
      status      <= res_status;
      data_offset <= res_offset;
    end
  end

endmodule

/* src/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator with coalescing
//
//  channel | handshake           | payload
//  s       | s_tvalid / s_tready | s_tuser kind; s_tdata request_bytes, block_address
//  m       | m_tvalid / m_tready | m_tdata status, data_offset
//  cfg     | cfg_valid/cfg_ready | cfg_data pool_bytes
//
// A token walks the cell chain one entry per cycle, but it stays on a
// cell for a free hit or a merge.
// rst restores a single free block over a 65536-byte pool; a cfg write
// rebuilds the table. A stalled m side holds the finished result while
// the next request may already be taken and walked.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_bytes[16:0], block_address[32:17], zero
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[1:0], data_offset[17:2], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  ffha_pkg::ctl_t   ctl;
  ffha_pkg::rep_t   rep;
  ffha_pkg::entry_t ent  [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t fwd  [ffha_pkg::MAX_BLOCKS];
  logic             tokf [ffha_pkg::MAX_BLOCKS];
  logic             mreq [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::rep_t   reps [ffha_pkg::MAX_BLOCKS];
  logic [1:0]                 status;
  logic [ffha_pkg::OFS_W-1:0] data_offset;

  for (genvar i = 0; i < ffha_pkg::MAX_BLOCKS; i++) begin : g_cell
    ffha_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .head        ((i == 0) ? 1'b1 : 1'b0),
      .ctl         (ctl),
      .left_fwd    ((i == 0) ? ffha_pkg::entry_t'('0) : fwd[(i == 0) ? 0 : i - 1]),
      .left_tok    ((i == 0) ? ctl.launch : tokf[(i == 0) ? 0 : i - 1]),
      .right_ent   ((i == ffha_pkg::MAX_BLOCKS - 1) ? ffha_pkg::entry_t'('0)
                     : ent[(i == ffha_pkg::MAX_BLOCKS - 1) ? i : i + 1]),
      .right_merge ((i == ffha_pkg::MAX_BLOCKS - 1) ? 1'b0
                     : mreq[(i == ffha_pkg::MAX_BLOCKS - 1) ? i : i + 1]),
      .ent_q       (ent[i]),
      .fwd         (fwd[i]),
      .tok_fwd     (tokf[i]),
      .merge_req   (mreq[i]),
      .rep         (reps[i])
    );
  end

  // only the token holder reports; gather by OR
  always_comb begin
    rep = '0;
    for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++) begin
      rep = rep | reps[i];
    end
  end

  ffha_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .kind          (s_tuser),
    .request_bytes (s_tdata[16:0]),
    .block_address (s_tdata[32:17]),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .status        (status),
    .data_offset   (data_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .rep           (rep),
    .tok_out       (tokf[ffha_pkg::MAX_BLOCKS-1]),
    .ctl           (ctl)
  );

  assign m_tdata = {6'd0, data_offset, status};

endmodule

/* dv/first_fit_heap_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb: self-checking bench for the heap allocator
// Drives alloc/free requests over several pool sizes, predicts every result
// from a private copy of the block table and compares status and offset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;

  localparam int HDR = 32;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic                        kind;
    logic [ffha_pkg::SIZE_W-1:0] nbytes;
    logic [ffha_pkg::OFS_W-1:0]  addr;
  } req_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [ffha_pkg::OFS_W-1:0] offset;
  } rsp_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // request_bytes[16:0], block_address[32:17], zero
  logic        s_tuser;   // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // status[1:0], data_offset[17:2], zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  first_fit_heap_allocator dut (.*);

  // shadow block table
  int unsigned blk_start[ffha_pkg::MAX_BLOCKS];
  int unsigned blk_size[ffha_pkg::MAX_BLOCKS];
  bit          blk_used[ffha_pkg::MAX_BLOCKS];
  int unsigned blk_count;

  req_t req_q[$];
  rsp_t want_q[$];
  int   errors = 0;
  int   cycles = 0;
  bit   s_taken = 1'b0;
  bit   calm = 1'b0;
  bit   cfg_pending = 1'b0;
  logic [16:0] cfg_value = '0;

  function automatic void table_reset(int unsigned v);
    if (v > 65536) v = 65536;
    if (v < 64) v = 64;
    for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++) begin
      blk_start[i] = 0; blk_size[i] = 0; blk_used[i] = 0;
    end
    blk_count = 1;
    blk_size[0] = v - HDR;
  endfunction

  function automatic void drop_block(int unsigned k);
    for (int unsigned j = k; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1]; blk_size[j] = blk_size[j+1];
      blk_used[j] = blk_used[j+1];
    end
    blk_count--;
    blk_start[blk_count] = 0; blk_size[blk_count] = 0; blk_used[blk_count] = 0;
  endfunction

  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int unsigned sz;
    int unsigned i;
    int unsigned k;
    o = '0;
    if (r.kind == ffha_pkg::KIND_ALLOC) begin
      sz = (int'(r.nbytes) + 7) & ~7;
      o.status = ffha_pkg::STAT_NOSPACE;
      for (i = 0; i < blk_count; i++) begin
        if (!blk_used[i] && blk_size[i] >= sz) begin
          blk_used[i] = 1;
          if (blk_size[i] > sz + HDR && blk_count < ffha_pkg::MAX_BLOCKS) begin
            for (int unsigned j = blk_count; j > i + 1; j--) begin
              blk_start[j] = blk_start[j-1]; blk_size[j] = blk_size[j-1];
              blk_used[j] = blk_used[j-1];
            end
            blk_start[i+1] = blk_start[i] + HDR + sz;
            blk_size[i+1] = blk_size[i] - HDR - sz;
            blk_used[i+1] = 0;
            blk_size[i] = sz;
            blk_count++;
          end
          o.status = ffha_pkg::STAT_OK;
          o.offset = ffha_pkg::OFS_W'(blk_start[i] + HDR);
          break;
        end
      end
    end else begin
      o.status = ffha_pkg::STAT_BADFREE;
      for (i = 0; i < blk_count; i++)
        if (blk_used[i] && blk_start[i] + HDR == r.addr) break;
      if (i < blk_count) begin
        blk_used[i] = 0;
        k = i;
        while (k > 0 && !blk_used[k-1]) k--;
        while (k + 1 < blk_count && !blk_used[k+1]) begin
          blk_size[k] += blk_size[k+1] + HDR;
          drop_block(k + 1);
        end
        o.status = ffha_pkg::STAT_OK;
      end
    end
    return o;
  endfunction

  function automatic req_t mk(logic kind, int unsigned nb, int unsigned ad);
    req_t r;
    r.kind = kind; r.nbytes = ffha_pkg::SIZE_W'(nb); r.addr = ffha_pkg::OFS_W'(ad);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tuser   <= 1'b0;
      s_tdata   <= '0;
      m_tready  <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
    end else begin
      // advance only once the held transaction was taken
      if (!s_tvalid || s_taken) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
          s_tvalid <= 1;
          s_tuser <= req_q[0].kind;
          s_tdata <= {7'd0, req_q[0].addr, req_q[0].nbytes};
          want_q.push_back(allocate_or_free(req_q.pop_front()));
        end else begin
          s_tvalid <= 0;
          s_tdata <= 40'({$urandom, $urandom});
        end
      end
      m_tready <= calm || $urandom_range(99) >= 20;
      cfg_valid <= cfg_pending && !(cfg_valid && cfg_ready);
      cfg_data <= cfg_value;
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    s_taken = s_tvalid && s_tready;
    if (!rst) begin
      cycles++;
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.offset = m_tdata[17:2];
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = want_q.pop_front();
          if (got.status !== want.status || got.offset !== want.offset) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status exp %0d got %0d, offset exp %h got %h",
                       want.status, got.status, want.offset, got.offset);
          end
        end
      end
      if (cycles > LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic drain();
    while (req_q.size() > 0 || s_tvalid || want_q.size() > 0) @(posedge clk);
    repeat (ffha_pkg::MAX_BLOCKS + 10) @(posedge clk);
  endtask

  task automatic set_pool(int unsigned v);
    cfg_value = 17'(v);
    table_reset(v);
    cfg_pending = 1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_pending = 0;
  endtask

  // mostly well-formed alloc/free traffic against live blocks
  task automatic random_traffic(int n, int unsigned max_req);
    int unsigned live[$];
    int unsigned pick;
    int unsigned idx;
    req_t r;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50 || live.size() == 0) begin
        r = mk(ffha_pkg::KIND_ALLOC, $urandom_range(max_req), $urandom);
        if ($urandom_range(30) == 0) r.nbytes = ffha_pkg::SIZE_W'($urandom);
      end else if (pick < 90) begin
        idx = $urandom_range(live.size() - 1);
        r = mk(ffha_pkg::KIND_FREE, $urandom, live[idx]);
        live.delete(idx);
      end else begin
        r = mk(ffha_pkg::KIND_FREE, $urandom, $urandom);
      end
      req_q.push_back(r);
      while (req_q.size() > 0 || s_tvalid) @(posedge clk);
      if (r.kind == ffha_pkg::KIND_ALLOC && want_q.size() > 0
          && want_q[$].status == ffha_pkg::STAT_OK)
        live.push_back(want_q[$].offset);
    end
  endtask

  initial begin
    table_reset(65536);
    rst = 1;
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: extremes, zero size, bad and double free, unused fields
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 0, 16'hFFFF));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 1, 0));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 65536, 0));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 100, 0));
    req_q.push_back(mk(ffha_pkg::KIND_FREE, 17'h1FFFF, 72));
    req_q.push_back(mk(ffha_pkg::KIND_FREE, 0, 72));
    req_q.push_back(mk(ffha_pkg::KIND_FREE, 0, 16'hFFFF));
    req_q.push_back(mk(ffha_pkg::KIND_FREE, 0, 0));
    req_q.push_back(mk(ffha_pkg::KIND_FREE, 0, 32));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 17'h1FFFF, 0));
    drain();
    set_pool(17'h1FFFF);
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 65536 - 32, 0));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 0, 0));
    drain();
    set_pool(0);
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 0, 0));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 0, 0));
    req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 32, 0));
    req_q.push_back(mk(ffha_pkg::KIND_FREE, 0, 32));
    drain();
    // fill the table so no split is possible
    set_pool(4096);
    for (int i = 0; i < 66; i++) req_q.push_back(mk(ffha_pkg::KIND_ALLOC, 8, 0));
    drain();

    set_pool(2048);
    random_traffic(150, 300);
    drain();
    calm = 1;
    set_pool(65536);
    random_traffic(100, 2000);
    drain();
    calm = 0;
    set_pool(1000);
    random_traffic(150, 200);
    drain();
    set_pool(64);
    random_traffic(40, 40);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/ffha_pkg.sv
src/ffha_cell.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator.sv
dv/first_fit_heap_allocator_tb.sv
